### hdl/cfr_pkg.sv
package cfr_pkg;

  localparam logic [7:0] HDR_FIRST    = 8'h55;
  localparam logic [7:0] HDR_SECOND   = 8'hAA;
  localparam logic [7:0] CODE_OK      = 8'h80;
  localparam logic [7:0] CODE_SUM_ERR = 8'h81;
  localparam logic [7:0] CODE_XOR_ERR = 8'h82;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_SUM_ERR = 2'd1;
  localparam logic [1:0] STATUS_XOR_ERR = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPLY   = 1'b1;

  localparam int unsigned REPLY_BEATS    = 6;
  localparam int unsigned CMD_FIFO_DEPTH = 4;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_HDR2  = 3'd1,
    PH_TYPE  = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_SUM   = 3'd5,
    PH_XOR   = 3'd6
  } phase_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] index;
    logic [7:0] value;
    logic [1:0] status;
  } cmd_t;

  function automatic logic [7:0] status_code(input logic [1:0] status);
    logic [7:0] code;
    case (status)
      STATUS_SUM_ERR: code = CODE_SUM_ERR;
      STATUS_XOR_ERR: code = CODE_XOR_ERR;
      default:        code = CODE_OK;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] reply_byte(input logic [2:0] beat, input logic [7:0] code);
    logic [7:0] b;
    case (beat)
      3'd0:    b = HDR_FIRST;
      3'd1:    b = HDR_SECOND;
      3'd3:    b = 8'h00;
      default: b = code;
    endcase
    return b;
  endfunction

endpackage

### hdl/cfr_parser.sv
module cfr_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  output logic             cmd_push_o,
  output cfr_pkg::cmd_t    cmd_o
);
  import cfr_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] count_q, count_d;
  logic [7:0] len_q, len_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] xor_q, xor_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      count_q <= '0;
      len_q   <= '0;
      sum_q   <= '0;
      xor_q   <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      xor_q   <= xor_d;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    len_d      = len_q;
    sum_d      = sum_q;
    xor_d      = xor_q;
    cmd_push_o = 1'b0;
    cmd_o      = '{kind: KIND_PAYLOAD, index: count_q, value: rx_byte_i, status: STATUS_OK};
    if (accept_i) begin
      unique case (phase_q)
        PH_HDR2: begin
          if (rx_byte_i == HDR_SECOND) begin
            phase_d = PH_TYPE;
            count_d = '0;
          end else begin
            phase_d = PH_HUNT;
          end
        end
        PH_TYPE: begin
          sum_d      = rx_byte_i;
          xor_d      = rx_byte_i;
          cmd_push_o = 1'b1;
          count_d    = count_q + 8'd1;
          phase_d    = PH_LEN;
        end
        PH_LEN: begin
          sum_d   = sum_q + rx_byte_i;
          xor_d   = xor_q ^ rx_byte_i;
          len_d   = rx_byte_i;
          phase_d = (rx_byte_i == 8'd0) ? PH_SUM : PH_DATA;
        end
        PH_DATA: begin
          sum_d      = sum_q + rx_byte_i;
          xor_d      = xor_q ^ rx_byte_i;
          cmd_push_o = 1'b1;
          count_d    = count_q + 8'd1;
          if (count_q == len_q) begin
            phase_d = PH_SUM;
          end
        end
        PH_SUM: begin
          if (sum_q == rx_byte_i) begin
            phase_d = PH_XOR;
          end else begin
            cmd_push_o   = 1'b1;
            cmd_o.kind   = KIND_REPLY;
            cmd_o.status = STATUS_SUM_ERR;
            phase_d      = PH_HUNT;
          end
        end
        PH_XOR: begin
          cmd_push_o   = 1'b1;
          cmd_o.kind   = KIND_REPLY;
          cmd_o.status = (xor_q == rx_byte_i) ? STATUS_OK : STATUS_XOR_ERR;
          phase_d      = PH_HUNT;
          count_d      = '0;
          sum_d        = '0;
          xor_d        = '0;
        end
        default: begin
          phase_d = (rx_byte_i == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
        end
      endcase
    end
  end

endmodule

### hdl/cfr_cmd_fifo.sv
module cfr_cmd_fifo #(
  parameter int unsigned Depth = cfr_pkg::CMD_FIFO_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cfr_pkg::cmd_t wdata_i,
  input  logic          pop_i,
  output cfr_pkg::cmd_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  import cfr_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### hdl/cfr_emitter.sv
module cfr_emitter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  cfr_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic          kind_o,
  output logic [7:0]    index_o,
  output logic [7:0]    value_o,
  output logic [1:0]    frame_status_o,
  output logic          last_o
);
  import cfr_pkg::*;

  logic       out_valid_q, out_valid_d;
  logic       kind_q, kind_d;
  logic [7:0] index_q, index_d;
  logic [7:0] value_q, value_d;
  logic [1:0] status_q, status_d;
  logic       last_q, last_d;

  logic       rep_active_q, rep_active_d;
  logic [2:0] beat_q, beat_d;
  logic [1:0] rep_status_q, rep_status_d;
  logic       load;

  assign load = !out_valid_q || pop_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    kind_d       = kind_q;
    index_d      = index_q;
    value_d      = value_q;
    status_d     = status_q;
    last_d       = last_q;
    rep_active_d = rep_active_q;
    beat_d       = beat_q;
    rep_status_d = rep_status_q;
    cmd_pop_o    = 1'b0;
    if (load) begin
      if (rep_active_q) begin
        out_valid_d = 1'b1;
        kind_d      = KIND_REPLY;
        index_d     = {5'd0, beat_q};
        value_d     = reply_byte(beat_q, status_code(rep_status_q));
        status_d    = rep_status_q;
        last_d      = (beat_q == 3'(REPLY_BEATS - 1));
        beat_d      = beat_q + 3'd1;
        if (beat_q == 3'(REPLY_BEATS - 1)) begin
          rep_active_d = 1'b0;
        end
      end else if (!cmd_empty_i) begin
        cmd_pop_o   = 1'b1;
        out_valid_d = 1'b1;
        kind_d      = cmd_i.kind;
        status_d    = cmd_i.status;
        if (cmd_i.kind == KIND_REPLY) begin
          index_d      = 8'd0;
          value_d      = HDR_FIRST;
          last_d       = 1'b0;
          rep_active_d = 1'b1;
          beat_d       = 3'd1;
          rep_status_d = cmd_i.status;
        end else begin
          index_d = cmd_i.index;
          value_d = cmd_i.value;
          last_d  = 1'b1;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      rep_active_q <= 1'b0;
      beat_q       <= '0;
    end else begin
      out_valid_q  <= out_valid_d;
      rep_active_q <= rep_active_d;
      beat_q       <= beat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    index_q      <= index_d;
    value_q      <= value_d;
    status_q     <= status_d;
    last_q       <= last_d;
    rep_status_q <= rep_status_d;
  end

  assign empty_o        = !out_valid_q;
  assign kind_o         = kind_q;
  assign index_o        = index_q;
  assign value_o        = value_q;
  assign frame_status_o = status_q;
  assign last_o         = last_q;

endmodule

### hdl/checked_frame_receiver.sv
// Checked frame receiver.
// Input queue: one received serial byte per item on rx_byte_i, taken on a
// clock edge with push high and full low. Result queue: the oldest result
// sits on kind_o/index_o/value_o/frame_status_o/last_o while empty is low
// and is taken on an edge with pop high.
// A byte is taken every cycle while full is low. A byte that causes a
// result (type, data, sum failure, xor byte) is written as a command into
// the command queue; the emitter moves it into the output register that
// drives the result ports once that register is free. A payload byte gives
// one item; a checked frame end gives a six-item reply, one item per cycle
// from the reply beat counter while pop keeps taking them.
// Between parser and emitter sits a small command queue (CmdFifoDepth
// entries); when the receiver stalls, the output register holds its item,
// the command queue fills and full rises, holding off further bytes.
// Reset clears the parser to the header hunt and empties all queues.
module checked_frame_receiver #(
  parameter int unsigned CmdFifoDepth = cfr_pkg::CMD_FIFO_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic       kind_o,
  output logic [7:0] index_o,
  output logic [7:0] value_o,
  output logic [1:0] frame_status_o,
  output logic       last_o
);
  import cfr_pkg::*;

  logic accept;
  logic cmd_push;
  cmd_t cmd_wr;
  cmd_t cmd_rd;
  logic cmd_pop;
  logic cmd_empty;

  assign accept = push && !full;

  cfr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_wr)
  );

  cfr_cmd_fifo #(
    .Depth (CmdFifoDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wr),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rd),
    .full_o  (full),
    .empty_o (cmd_empty)
  );

  cfr_emitter u_emitter (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_empty_i    (cmd_empty),
    .cmd_i          (cmd_rd),
    .cmd_pop_o      (cmd_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .kind_o         (kind_o),
    .index_o        (index_o),
    .value_o        (value_o),
    .frame_status_o (frame_status_o),
    .last_o         (last_o)
  );

endmodule
